@@ src/lcgpf_pkg.sv @@
`default_nettype none
package lcgpf_pkg;

    // Field and register widths.
    localparam int MULT_W  = 16;
    localparam int INCR_W  = 16;
    localparam int MOD_W   = 15;
    localparam int SEED_W  = 14;
    localparam int VALUE_W = 14;
    localparam int COUNT_W = 15;

    // Configuration port.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MULTIPLIER = 2'd0,
        REG_INCREMENT  = 2'd1,
        REG_MODULUS    = 2'd2,
        REG_SEED       = 2'd3
    } t_reg_idx;

    // Register reset values.
    localparam logic [MULT_W-1:0] MULT_RST = 16'd1;
    localparam logic [INCR_W-1:0] INCR_RST = 16'd0;
    localparam logic [MOD_W-1:0]  MOD_RST  = 15'd10000;
    localparam logic [SEED_W-1:0] SEED_RST = 14'd0;

    // Default depth of the visited map.
    localparam int MAX_MOD_DEF = 16384;

    // a*x + c stays below 2^31 for a 16-bit a and c and a 15-bit x.
    localparam int PROD_W = 31;
    localparam int DIV_CNT_W = 5;

    // Generation tag kept per map entry.
    localparam int EPOCH_W = 4;

    // Wide enough to hold any map address for a depth up to 65536.
    localparam int ADDR_XW = 17;

endpackage
`default_nettype wire

@@ src/lcgpf_in_if.sv @@
`default_nettype none
interface lcgpf_in_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface
`default_nettype wire

@@ src/lcgpf_out_if.sv @@
`default_nettype none
interface lcgpf_out_if
    import lcgpf_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               value_valid;
    logic               finished;
    logic [COUNT_W-1:0] distinct_seen;

    modport source (output valid, output value, output value_valid, output finished,
                    output distinct_seen, input ready);
    modport sink   (input valid, input value, input value_valid, input finished,
                    input distinct_seen, output ready);
endinterface
`default_nettype wire

@@ src/lcgpf_div.sv @@
`default_nettype none
module lcgpf_div
    import lcgpf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [PROD_W-1:0] i_dividend,
    input  wire logic [MOD_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [MOD_W-1:0]       o_rem
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(PROD_W - 1);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [PROD_W-1:0]    r_dvd;
    logic [MOD_W-1:0]     r_den;
    logic [MOD_W-1:0]     r_rem;

    logic [MOD_W:0]       w_trial;
    logic [MOD_W:0]       w_diff;
    logic [MOD_W-1:0]     n_rem;

    // One restoring step: shift in the next dividend bit and subtract if it fits.
    assign w_trial = {r_rem, r_dvd[PROD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign n_rem   = (w_trial >= {1'b0, r_den}) ? w_diff[MOD_W-1:0] : w_trial[MOD_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_den <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rem < r_den))
        else $error("partial remainder not below divisor");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");

endmodule
`default_nettype wire

@@ src/lcg_period_finder.sv @@
`default_nettype none
// Channel  | Dir | Payload                                        | Handshake
// i_in     | in  | restart                                        | valid/ready
// o_out    | out | value, value_valid, finished, distinct_seen    | valid/ready
// i_cfg_*  | in  | i_cfg_idx selects a register, i_cfg_data value | i_cfg_we
//
// A step word runs the 31-step restoring divider that reduces a*x + c by the modulus;
// finished words are answered without a division.
// A restart marks the seed, after a clearing pass over all MAX_MOD map entries on the
// first restart after reset and on every 15th restart after that (visited tags wrap).
// Reset is synchronous and active low; configuration returns to its defaults.
// A result waits in the output register; a new word is accepted meanwhile, and
// the sequencer holds in its final state until the output register is free.
module lcg_period_finder
    import lcgpf_pkg::*;
#(
    parameter int MAX_MOD = MAX_MOD_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    lcgpf_in_if.sink                   i_in,
    lcgpf_out_if.source                o_out
);

    localparam int AW = (MAX_MOD > 1) ? $clog2(MAX_MOD) : 1;
    localparam logic [AW-1:0]      SWEEP_LAST = AW'(MAX_MOD - 1);
    localparam logic [ADDR_XW-1:0] MAX_MOD_X  = ADDR_XW'(MAX_MOD);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SWEEP = 8'b0000_0010,
        S_SEED  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_DIVST = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_CHK   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Configuration registers.
    logic [MULT_W-1:0] r_mult;
    logic [INCR_W-1:0] r_incr;
    logic [MOD_W-1:0]  r_mod;
    logic [SEED_W-1:0] r_seed;

    // Generator state.
    logic [MOD_W-1:0]   r_cur;
    logic [COUNT_W-1:0] r_distinct;
    logic               r_done;
    logic [EPOCH_W-1:0] r_epoch;
    logic [AW-1:0]      r_sweep;
    logic [PROD_W-1:0]  r_prod;

    // Pending result.
    logic [VALUE_W-1:0] r_res_value;
    logic               r_res_vv;
    logic               r_res_fin;
    logic [COUNT_W-1:0] r_res_cnt;

    // Output register.
    logic               r_o_valid;
    logic [VALUE_W-1:0] r_o_value;
    logic               r_o_vv;
    logic               r_o_fin;
    logic [COUNT_W-1:0] r_o_cnt;

    // Visited map: each entry holds the tag of the run that last marked it.
    logic [EPOCH_W-1:0] r_tag_mem [MAX_MOD];
    logic [EPOCH_W-1:0] r_rd_tag;

    logic [ADDR_XW-1:0] w_mod_x;
    logic [ADDR_XW-1:0] w_mod_sat;
    logic [MOD_W-1:0]   w_m;
    logic               w_seed_in;
    logic [ADDR_XW-1:0] w_seed_x;
    logic [ADDR_XW-1:0] w_rem_x;
    logic [AW-1:0]      w_seed_addr;
    logic [AW-1:0]      w_rem_addr;
    logic [PROD_W-1:0]  w_mac;
    logic               w_div_start;
    logic               w_div_done;
    logic [MOD_W-1:0]   w_div_rem;
    logic               w_in_acc;
    logic               w_out_free;
    logic               w_seen;
    logic [COUNT_W-1:0] w_cnt_inc;
    logic               w_mem_we;
    logic [AW-1:0]      w_mem_addr;
    logic [EPOCH_W-1:0] w_mem_tag;

    // A zero modulus acts as one; a modulus above the map depth is clipped.
    assign w_mod_x   = ADDR_XW'(r_mod);
    assign w_mod_sat = (w_mod_x > MAX_MOD_X) ? MAX_MOD_X : w_mod_x;
    assign w_m       = (r_mod == '0) ? MOD_W'(1) : w_mod_sat[MOD_W-1:0];

    assign w_seed_in   = ({1'b0, r_seed} < w_m);
    assign w_seed_x    = ADDR_XW'(r_seed);
    assign w_rem_x     = ADDR_XW'(w_div_rem);
    assign w_seed_addr = w_seed_x[AW-1:0];
    assign w_rem_addr  = w_rem_x[AW-1:0];

    assign w_mac = PROD_W'(r_mult) * PROD_W'(r_cur) + PROD_W'(r_incr);

    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_out_free  = !r_o_valid || o_out.ready;
    assign w_div_start = (r_state == S_DIVST);
    assign w_seen      = (r_rd_tag == r_epoch);
    assign w_cnt_inc   = r_distinct + 1'b1;

    lcgpf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_prod),
        .i_divisor  (w_m),
        .o_done     (w_div_done),
        .o_rem      (w_div_rem)
    );

    // Map write port: clearing pass, seed mark, or mark of a new value.
    always_comb begin
        w_mem_we   = 1'b0;
        w_mem_addr = w_rem_addr;
        w_mem_tag  = r_epoch;
        case (r_state)
            S_SWEEP: begin
                w_mem_we   = 1'b1;
                w_mem_addr = r_sweep;
                w_mem_tag  = '0;
            end
            S_SEED: begin
                w_mem_we   = w_seed_in;
                w_mem_addr = w_seed_addr;
            end
            S_CHK: begin
                w_mem_we = !w_seen;
            end
            default: begin
                w_mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_tag_mem[w_mem_addr] <= w_mem_tag;
        end
        r_rd_tag <= r_tag_mem[w_rem_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    if (i_in.restart) begin
                        n_state = (r_epoch == '1) ? S_SWEEP : S_SEED;
                    end else if (r_done || (r_distinct >= w_m)) begin
                        n_state = S_EMIT;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_SWEEP: begin
                if (r_sweep == SWEEP_LAST) begin
                    n_state = S_SEED;
                end
            end
            S_SEED:  n_state = S_EMIT;
            S_MUL:   n_state = S_DIVST;
            S_DIVST: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK:   n_state = S_EMIT;
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_mult     <= MULT_RST;
            r_incr     <= INCR_RST;
            r_mod      <= MOD_RST;
            r_seed     <= SEED_RST;
            r_cur      <= '0;
            r_distinct <= '0;
            r_done     <= 1'b1;
            r_epoch    <= '1;
            r_sweep    <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (t_reg_idx'(i_cfg_idx))
                    REG_MULTIPLIER: r_mult <= i_cfg_data[MULT_W-1:0];
                    REG_INCREMENT:  r_incr <= i_cfg_data[INCR_W-1:0];
                    REG_MODULUS:    r_mod  <= i_cfg_data[MOD_W-1:0];
                    REG_SEED:       r_seed <= i_cfg_data[SEED_W-1:0];
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in.restart) begin
                        r_sweep <= '0;
                        if (r_epoch != '1) begin
                            r_epoch <= r_epoch + 1'b1;
                        end
                    end else if (w_in_acc && !r_done && (r_distinct >= w_m)) begin
                        r_done <= 1'b1;
                    end
                end
                S_SWEEP: begin
                    r_sweep <= r_sweep + 1'b1;
                    if (r_sweep == SWEEP_LAST) begin
                        r_epoch <= EPOCH_W'(1);
                    end
                end
                S_SEED: begin
                    r_cur      <= MOD_W'(r_seed);
                    r_distinct <= COUNT_W'(1);
                    r_done     <= 1'b0;
                end
                S_CHK: begin
                    if (w_seen) begin
                        r_done <= 1'b1;
                    end else begin
                        r_cur      <= w_div_rem;
                        r_distinct <= w_cnt_inc;
                    end
                end
                default: ;
            endcase

            if ((r_state == S_EMIT) && w_out_free) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_res_value <= '0;
                r_res_vv    <= 1'b0;
                r_res_fin   <= 1'b1;
                r_res_cnt   <= r_distinct;
            end
            S_SEED: begin
                r_res_value <= r_seed;
                r_res_vv    <= 1'b1;
                r_res_fin   <= 1'b0;
                r_res_cnt   <= COUNT_W'(1);
            end
            S_CHK: begin
                r_res_value <= w_seen ? '0 : w_div_rem[VALUE_W-1:0];
                r_res_vv    <= !w_seen;
                r_res_fin   <= w_seen;
                r_res_cnt   <= w_seen ? r_distinct : w_cnt_inc;
            end
            default: ;
        endcase

        if (r_state == S_MUL) begin
            r_prod <= w_mac;
        end

        if ((r_state == S_EMIT) && w_out_free) begin
            r_o_value <= r_res_value;
            r_o_vv    <= r_res_vv;
            r_o_fin   <= r_res_fin;
            r_o_cnt   <= r_res_cnt;
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = r_o_valid;
    assign o_out.value         = r_o_value;
    assign o_out.value_valid   = r_o_vv;
    assign o_out.finished      = r_o_fin;
    assign o_out.distinct_seen = r_o_cnt;

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("run tag reached the cleared value");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the wait state");

    a_new_value_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CHK) && !w_seen) |=> (r_distinct == $past(w_cnt_inc)))
        else $error("new value did not advance the distinct count");

    a_emit_loads_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMIT) && w_out_free) |=> (r_o_valid && (r_state == S_IDLE)))
        else $error("finished result not placed in the output register");

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
    import lcgpf_pkg::*;

    localparam int WATCHDOG_LIMIT = 70000;
    localparam int RANDOM_WORDS   = 1100;
    localparam int STEADY_WORDS   = 50;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               value_valid;
        logic               finished;
        logic [COUNT_W-1:0] distinct_seen;
    } t_lcg_word;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    lcgpf_in_if  gen_req ();
    lcgpf_out_if gen_rsp ();

    lcg_period_finder uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (gen_req),
        .o_out      (gen_rsp)
    );

    // Shadow copy of the generator: registers and sequence state.
    logic [MULT_W-1:0]  mult_reg = MULT_RST;
    logic [INCR_W-1:0]  incr_reg = INCR_RST;
    logic [MOD_W-1:0]   mod_reg  = MOD_RST;
    logic [SEED_W-1:0]  seed_reg = SEED_RST;
    logic [VALUE_W-1:0] x_now      = '0;
    logic [COUNT_W-1:0] seen_total = '0;
    bit                 seq_done   = 1'b1;
    bit                 visited [MAX_MOD_DEF];

    t_lcg_word lcg_words_due[$];
    int        words_sent     = 0;
    int        words_checked  = 0;
    int        mismatch_count = 0;
    int        send_gap_pct   = 0;
    int        sink_gap_pct   = 0;
    int        stall_left     = 0;
    int        quiet_cycles   = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int unsigned eff_modulus();
        if (mod_reg == '0)
            return 1;
        if (mod_reg > MAX_MOD_DEF)
            return MAX_MOD_DEF;
        return int'(mod_reg);
    endfunction

    function automatic t_lcg_word lcg_predict_step(input logic restart);
        int unsigned     m_eff;
        longint unsigned next_x;
        t_lcg_word       w;
        m_eff = eff_modulus();
        w = '0;
        if (restart) begin
            foreach (visited[k])
                visited[k] = 1'b0;
            x_now = seed_reg;
            // A seed outside the modulus is emitted but never marked.
            if (seed_reg < m_eff)
                visited[seed_reg] = 1'b1;
            seen_total = COUNT_W'(1);
            seq_done = 1'b0;
            w.value = x_now;
            w.value_valid = 1'b1;
            w.distinct_seen = seen_total;
            return w;
        end
        w.finished = 1'b1;
        w.distinct_seen = seen_total;
        if (seq_done)
            return w;
        if (seen_total >= m_eff) begin
            seq_done = 1'b1;
            return w;
        end
        next_x = (64'(mult_reg) * 64'(x_now) + 64'(incr_reg)) % 64'(m_eff);
        if (visited[next_x[VALUE_W-1:0]]) begin
            seq_done = 1'b1;
            return w;
        end
        visited[next_x[VALUE_W-1:0]] = 1'b1;
        x_now = next_x[VALUE_W-1:0];
        seen_total = seen_total + 1'b1;
        w.value = x_now;
        w.value_valid = 1'b1;
        w.finished = 1'b0;
        w.distinct_seen = seen_total;
        return w;
    endfunction

    function automatic void note_mismatch(input string field, input int unsigned want,
                                          input int unsigned got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("word %0d: %s expected %0d, got %0d", words_checked, field, want, got);
    endfunction

    // Offers one word, possibly after a gap, and records its prediction once taken.
    task automatic send_word(input logic restart);
        if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct) begin
            gen_req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        gen_req.valid   <= 1'b1;
        gen_req.restart <= restart;
        @(posedge i_clk);
        while (!gen_req.ready)
            @(posedge i_clk);
        lcg_words_due.push_back(lcg_predict_step(restart));
        words_sent++;
    endtask

    task automatic wait_idle();
        gen_req.valid <= 1'b0;
        while (lcg_words_due.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_MULTIPLIER: mult_reg = data[MULT_W-1:0];
            REG_INCREMENT:  incr_reg = data[INCR_W-1:0];
            REG_MODULUS:    mod_reg  = data[MOD_W-1:0];
            REG_SEED:       seed_reg = data[SEED_W-1:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_regs(input logic [15:0] a, input logic [15:0] c,
                             input logic [15:0] m, input logic [15:0] x0);
        wait_idle();
        write_reg(REG_MULTIPLIER, a);
        write_reg(REG_INCREMENT, c);
        write_reg(REG_MODULUS, m);
        write_reg(REG_SEED, x0);
        end_writes();
    endtask

    function automatic logic [15:0] pick_coeff();
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'h0001;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly small moduli so that runs close quickly; now and then the extremes.
    task automatic randomize_regs(input logic [3:0] mask);
        logic [MOD_W-1:0] m;
        logic [SEED_W-1:0] x0;
        if (mask[REG_MULTIPLIER])
            write_reg(REG_MULTIPLIER, pick_coeff());
        if (mask[REG_INCREMENT])
            write_reg(REG_INCREMENT, pick_coeff());
        if (mask[REG_MODULUS]) begin
            case ($urandom_range(0, 19))
                0:       m = '0;
                1:       m = 15'd16384;
                2:       m = 15'h7FFF;
                3:       m = 15'($urandom_range(16385, 32767));
                4, 5:    m = 15'($urandom_range(49, 16383));
                default: m = 15'($urandom_range(1, 48));
            endcase
            write_reg(REG_MODULUS, {1'($urandom_range(0, 1)), m});
        end
        if (mask[REG_SEED]) begin
            if ($urandom_range(0, 4) != 0)
                x0 = 14'($urandom_range(0, eff_modulus() - 1));
            else
                x0 = 14'($urandom_range(0, 16383));
            write_reg(REG_SEED, {2'($urandom_range(0, 3)), x0});
        end
        end_writes();
    endtask

    task automatic test_before_restart();
        send_word(1'b0);
        send_word(1'b0);
    endtask

    task automatic test_reset_settings();
        // With a = 1 and c = 0 the seed repeats on the first step.
        send_word(1'b1);
        send_word(1'b0);
        send_word(1'b0);
    endtask

    task automatic test_count_limit();
        load_regs(16'd1, 16'd1, 16'd4, 16'd0);
        send_word(1'b1);
        repeat (4) send_word(1'b0);
    endtask

    task automatic test_modulus_extremes();
        load_regs(16'd3, 16'd7, 16'd0, 16'd0);
        send_word(1'b1);
        repeat (2) send_word(1'b0);
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h3FFF);
        send_word(1'b1);
        repeat (3) send_word(1'b0);
    endtask

    task automatic test_seed_outside_modulus();
        load_regs(16'd1, 16'd1, 16'd5, 16'd9);
        send_word(1'b1);
        repeat (6) send_word(1'b0);
    endtask

    // The sink holds off long enough for the block to fill and stall its input.
    task automatic test_output_stall();
        load_regs(16'd1, 16'd1, 16'd16384, 16'd0);
        send_gap_pct = 0;
        sink_gap_pct = 0;
        stall_left = 400;
        send_word(1'b1);
        repeat (12) send_word(1'b0);
    endtask

    task automatic test_random_runs(input int target, input bit gaps);
        int kind;
        int cap;
        while (words_sent < target) begin
            wait_idle();
            send_gap_pct = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(5, 40) : 0;
            sink_gap_pct = (gaps && $urandom_range(0, 3) != 0) ? $urandom_range(5, 40) : 0;
            randomize_regs(4'($urandom_range(0, 15)));
            cap = (eff_modulus() < 40) ? eff_modulus() : 40;
            kind = $urandom_range(0, 9);
            if (kind < 8) begin
                // Now and then a run goes on under the new settings without a restart.
                if (kind != 0)
                    send_word(1'b1);
                repeat ($urandom_range(1, cap + 2)) send_word(1'b0);
            end else begin
                repeat ($urandom_range(8, 20)) send_word($urandom_range(0, 3) == 0);
            end
        end
    endtask

    initial begin : result_sink
        int gap_left;
        gap_left = 0;
        gen_rsp.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                gen_rsp.ready <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left--;
                gen_rsp.ready <= 1'b0;
            end else if (sink_gap_pct > 0 && $urandom_range(1, 100) <= sink_gap_pct) begin
                gap_left = $urandom_range(0, 7);
                gen_rsp.ready <= 1'b0;
            end else begin
                gen_rsp.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_words
        t_lcg_word want;
        if (i_rst_n && gen_rsp.valid && gen_rsp.ready) begin
            if (lcg_words_due.size() == 0) begin
                note_mismatch("unexpected word, distinct_seen", 0, gen_rsp.distinct_seen);
            end else begin
                want = lcg_words_due.pop_front();
                if (gen_rsp.value !== want.value)
                    note_mismatch("value", want.value, gen_rsp.value);
                if (gen_rsp.value_valid !== want.value_valid)
                    note_mismatch("value_valid", want.value_valid, gen_rsp.value_valid);
                if (gen_rsp.finished !== want.finished)
                    note_mismatch("finished", want.finished, gen_rsp.finished);
                if (gen_rsp.distinct_seen !== want.distinct_seen)
                    note_mismatch("distinct_seen", want.distinct_seen, gen_rsp.distinct_seen);
            end
            words_checked++;
        end
    end

    // The first restart after reset includes a full clearing pass of the map.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (gen_req.valid && gen_req.ready)
                || (gen_rsp.valid && gen_rsp.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no word moved for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n         <= 1'b0;
        i_cfg_we        <= 1'b0;
        i_cfg_idx       <= REG_MULTIPLIER;
        i_cfg_data      <= '0;
        gen_req.valid   <= 1'b0;
        gen_req.restart <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_before_restart();
        test_reset_settings();
        test_count_limit();
        test_modulus_extremes();
        test_seed_outside_modulus();
        test_output_stall();
        test_random_runs(RANDOM_WORDS, 1'b1);
        test_random_runs(words_sent + STEADY_WORDS, 1'b0);

        wait_idle();
        repeat (80) @(posedge i_clk);
        if (lcg_words_due.size() != 0)
            $display("%0d expected words never arrived", lcg_words_due.size());
        if (mismatch_count == 0 && lcg_words_due.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

@@ files.f @@
src/lcgpf_pkg.sv
src/lcgpf_in_if.sv
src/lcgpf_out_if.sv
src/lcgpf_div.sv
src/lcg_period_finder.sv
tb/tb_top.sv
